// ----- design/dtsr_pkg.sv -----
// Shared types and constants for the reflectance correction block.
`timescale 1ns / 1ps
`default_nettype none
package dtsr_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned ReflW  = 17;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned QuoW   = 48;
  localparam int unsigned DvsW   = 49;

  localparam logic [ReflW-1:0] ONE_Q16 = 17'd65536;

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_ENABLE  = 3'd0;
  localparam logic [IdxW-1:0] REG_GAIN    = 3'd1;
  localparam logic [IdxW-1:0] REG_BIAS    = 3'd2;
  localparam logic [IdxW-1:0] REG_COEF_XA = 3'd3;
  localparam logic [IdxW-1:0] REG_COEF_XB = 3'd4;
  localparam logic [IdxW-1:0] REG_COEF_XC = 3'd5;
  localparam logic [IdxW-1:0] REG_MIN_PIX = 3'd6;

  // How the back end treats a request
  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_NULL,
    KIND_CORR
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CountW-1:0] count;
  } entry_t;

  typedef struct packed {
    logic signed [31:0] gain;
    logic signed [31:0] bias;
    logic signed [31:0] coef_xa;
    logic signed [31:0] coef_xb;
    logic signed [31:0] coef_xc;
    logic [ReflW-1:0]   min_pix;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAD,
    ST_Y,
    ST_DEN,
    ST_PREP,
    ST_DIV,
    ST_CLAMP,
    ST_DONE
  } state_t;

  // Saturate a 50-bit signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) r = 32'sh7fffffff;
    else if (v < -50'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/dtsr_front.sv -----
// Front end: accepts requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module dtsr_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            enable,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [15:0]     pixel_count,
  output logic                 q_valid,
  input  wire logic            q_pop,
  output dtsr_pkg::entry_t     q_head
);
  import dtsr_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  entry_t     ent_in;

  // Classify the incoming count
  always_comb begin
    ent_in.count = pixel_count;
    if (!enable) ent_in.kind = KIND_PASS;
    else if (pixel_count == '0) ent_in.kind = KIND_NULL;
    else ent_in.kind = KIND_CORR;
  end

  assign in_stall = fill[1];
  assign push     = in_valid && !in_stall;
  assign q_valid  = fill != 2'd0;
  assign pop      = q_pop && q_valid;
  assign q_head   = slots[rd_ptr];

  // Two-entry queue
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= ent_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ----- design/dtsr_back.sv -----
// Back end: radiance, correction, bit-serial divide, clamp, statistics and output register.
`timescale 1ns / 1ps
`default_nettype none
module dtsr_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dtsr_pkg::cfg_t    cfg,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire dtsr_pkg::entry_t  q_head,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [16:0]            reflectance,
  output logic                   is_null,
  output logic [16:0]            running_min,
  output logic [16:0]            running_max
);
  import dtsr_pkg::*;

  state_t state;
  state_t state_next;

  entry_t                 ent;
  logic signed [31:0]     rad;
  logic signed [31:0]     y;
  logic signed [DvsW-1:0] den;
  logic [DvsW-1:0]        dvs;
  logic [QuoW-1:0]        dvd;
  logic [DvsW-1:0]        rem;
  logic [QuoW-1:0]        quo;
  logic [5:0]             cnt;
  logic                   neg;
  logic                   zero_div;
  logic [ReflW-1:0]       res;
  logic [ReflW-1:0]       stat_min;
  logic [ReflW-1:0]       stat_max;

  logic signed [48:0]     prod_rad;
  logic signed [49:0]     rad_sum;
  logic signed [63:0]     prod_y;
  logic signed [49:0]     y_diff;
  logic signed [63:0]     prod_den;
  logic [DvsW:0]          rem_sh;
  logic [DvsW:0]          rem_sub;
  logic                   out_load;
  logic [QuoW-1:0]        mag;
  logic [ReflW-1:0]       clamped;

  // Arithmetic for each step
  always_comb begin
    prod_rad = cfg.gain * $signed({1'b0, ent.count});
    rad_sum  = 50'(prod_rad) + 50'(cfg.bias);
    prod_y   = 64'(rad) * 64'(cfg.coef_xa);
    y_diff   = 50'(prod_y >>> 16) - 50'(cfg.coef_xb);
    prod_den = 64'(y) * 64'(cfg.coef_xc);
    rem_sh   = {rem, dvd[QuoW-1]};
    rem_sub  = rem_sh - {1'b0, dvs};
  end

  // Clamp of the quotient
  always_comb begin
    mag = zero_div ? QuoW'(ONE_Q16) : quo;
    if ((neg && !zero_div && quo != '0) || mag <= QuoW'(cfg.min_pix)) clamped = cfg.min_pix;
    else if (mag < QuoW'(ONE_Q16)) clamped = mag[ReflW-1:0];
    else clamped = ONE_Q16;
  end

  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) state_next = (q_head.kind == KIND_CORR) ? ST_RAD : ST_DONE;
      end
      ST_RAD:  state_next = ST_Y;
      ST_Y:    state_next = ST_DEN;
      ST_DEN:  state_next = ST_PREP;
      ST_PREP: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == '0) state_next = ST_CLAMP;
      end
      ST_CLAMP: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_pop = (state == ST_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ent <= q_head;
        res <= (q_head.kind == KIND_PASS) ? {1'b0, q_head.count} : '0;
      end
      ST_RAD: rad <= sat32(rad_sum);
      ST_Y:   y <= sat32(y_diff);
      ST_DEN: den <= DvsW'(prod_den >>> 16) + DvsW'(ONE_Q16);
      ST_PREP: begin
        zero_div <= den == '0;
        neg      <= y[31] ^ den[DvsW-1];
        dvs      <= den[DvsW-1] ? DvsW'(-den) : DvsW'(den);
        dvd      <= {(y[31] ? 32'(-y) : 32'(y)), 16'd0};
        rem      <= '0;
        quo      <= '0;
        cnt      <= 6'(QuoW - 1);
      end
      ST_DIV: begin
        if (!rem_sub[DvsW]) begin
          rem <= rem_sub[DvsW-1:0];
          quo <= {quo[QuoW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DvsW-1:0];
          quo <= {quo[QuoW-2:0], 1'b0};
        end
        dvd <= {dvd[QuoW-2:0], 1'b0};
        cnt <= cnt - 6'd1;
      end
      ST_CLAMP: res <= clamped;
      default: ;
    endcase
  end

  // Running statistics, with the min test taking priority
  always_ff @(posedge clk) begin
    if (rst) begin
      stat_min <= ONE_Q16;
      stat_max <= '0;
    end else if (state == ST_CLAMP) begin
      if (clamped < stat_min) stat_min <= clamped;
      else if (clamped > stat_max) stat_max <= clamped;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      reflectance <= res;
      is_null     <= ent.count == '0;
      running_min <= stat_min;
      running_max <= stat_max;
    end
  end

endmodule
`default_nettype wire

// ----- design/dn_to_surface_reflectance.sv -----
// Top level: configuration registers, front end, back end.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | pixel_count
//  out     | output    | out_valid/out_stall | reflectance, is_null, running_min, running_max
//  cfg     | input     | wr_en               | wr_index, wr_data
//
// A corrected pixel passes through RAD, Y, DEN, PREP, the 48-step bit-serial
// divider and CLAMP in the back end; pass-through and null pixels go from IDLE to DONE.
// A two-entry queue lets the input keep accepting while the back end works.
// Synchronous reset returns control, configuration and statistics to their defaults.
// The result register holds while out_valid and out_stall are both high.
`timescale 1ns / 1ps
`default_nettype none
module dn_to_surface_reflectance (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] pixel_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [16:0]      reflectance,
  output logic             is_null,
  output logic [16:0]      running_min,
  output logic [16:0]      running_max,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [31:0] wr_data
);
  import dtsr_pkg::*;

  logic   enable;
  cfg_t   cfg;
  logic   q_valid;
  logic   q_pop;
  entry_t q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      cfg.gain    <= 32'sd65536;
      cfg.bias    <= '0;
      cfg.coef_xa <= 32'sd65536;
      cfg.coef_xb <= 32'sd65536;
      cfg.coef_xc <= 32'sd65536;
      cfg.min_pix <= 17'd1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ENABLE:  enable      <= wr_data[0];
        REG_GAIN:    cfg.gain    <= wr_data;
        REG_BIAS:    cfg.bias    <= wr_data;
        REG_COEF_XA: cfg.coef_xa <= wr_data;
        REG_COEF_XB: cfg.coef_xb <= wr_data;
        REG_COEF_XC: cfg.coef_xc <= wr_data;
        REG_MIN_PIX: cfg.min_pix <= wr_data[ReflW-1:0];
        default: ;
      endcase
    end
  end

  dtsr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .enable      (enable),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_count (pixel_count),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_head      (q_head)
  );

  dtsr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_head      (q_head),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reflectance (reflectance),
    .is_null     (is_null),
    .running_min (running_min),
    .running_max (running_max)
  );

  // A null request always reports zero
  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_null |-> reflectance == '0)
    else $error("null request with nonzero reflectance");

  // Running minimum never exceeds 1.0, its reset value
  a_stat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> running_min <= ONE_Q16)
    else $error("running minimum out of range");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({reflectance, is_null, running_min, running_max}))
    else $error("stalled result changed");

endmodule
`default_nettype wire

// ----- test/dn_to_surface_reflectance_test.sv -----
// Testbench for the reflectance correction block: directed and random requests checked
// against a fixed-point predictor.
`timescale 1ns / 1ps
`default_nettype none
module dn_to_surface_reflectance_test;
  import dtsr_pkg::*;

  localparam longint CycleLimit = 3000000;
  localparam logic [2:0] RegUnknown = 3'd7;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] pixel_count;
  logic        out_valid;
  logic        out_stall;
  logic [16:0] reflectance;
  logic        is_null;
  logic [16:0] running_min;
  logic [16:0] running_max;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [31:0] wr_data;

  dn_to_surface_reflectance uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pixel_count(pixel_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .reflectance(reflectance), .is_null(is_null),
    .running_min(running_min), .running_max(running_max),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  typedef struct {
    logic [16:0] refl;
    logic        null_flag;
    logic [16:0] rmin;
    logic [16:0] rmax;
  } pixel_result_t;

  // Predictor copy of configuration and statistics
  logic        p_enable;
  longint      p_gain, p_bias, p_xa, p_xb, p_xc;
  logic [16:0] p_min_pix;
  logic [16:0] p_stat_min, p_stat_max;

  pixel_result_t pending_results[$];
  int  error_count;
  longint cycle_count;
  bit  hold_off;    // long receiver hold-off requested
  bit  rx_noise;    // random receiver stalls allowed

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("dn_to_surface_reflectance verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_div16(input longint v);
    longint q;
    q = v / 65536;
    if ((v % 65536) != 0 && v < 0) q = q - 1;
    return q;
  endfunction

  // Work out the result of one pixel and update the statistics
  function automatic pixel_result_t correct_pixel(input logic [15:0] cnt);
    pixel_result_t res;
    longint rad, y, den, r;
    res.null_flag = (cnt == 16'd0);
    if (!p_enable) begin
      res.refl = {1'b0, cnt};
    end else if (res.null_flag) begin
      res.refl = '0;
    end else begin
      rad = clip32(p_gain * longint'(cnt) + p_bias);
      y = clip32(floor_div16(rad * p_xa) - p_xb);
      den = 65536 + floor_div16(p_xc * y);
      if (den == 0) r = 65536;
      else r = (y * 65536) / den;
      if (r > longint'(p_min_pix)) r = (r < 65536) ? r : 65536;
      else r = longint'(p_min_pix);
      res.refl = r[16:0];
      if (res.refl < p_stat_min) p_stat_min = res.refl;
      else if (res.refl > p_stat_max) p_stat_max = res.refl;
    end
    res.rmin = p_stat_min;
    res.rmax = p_stat_max;
    return res;
  endfunction

  // One register write; the write port is idle again when the task returns
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_ENABLE:  p_enable = val[0];
      REG_GAIN:    p_gain = longint'(signed'(val));
      REG_BIAS:    p_bias = longint'(signed'(val));
      REG_COEF_XA: p_xa = longint'(signed'(val));
      REG_COEF_XB: p_xb = longint'(signed'(val));
      REG_COEF_XC: p_xc = longint'(signed'(val));
      REG_MIN_PIX: p_min_pix = val[16:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    repeat (n) @(posedge clk);
  endtask

  // Offer one request and hold it until accepted; valid stays up for the next one
  task automatic send_pixel(input logic [15:0] cnt, input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
      idle_gap();
    end
    in_valid <= 1'b1;
    pixel_count <= cnt;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(correct_pixel(cnt));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else if (rx_noise) out_stall <= ($urandom_range(0, 4) == 0);
    else out_stall <= 1'b0;
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result at cycle %0d", cycle_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (reflectance !== want.refl) report_mismatch("reflectance", reflectance, want.refl);
        if (is_null !== want.null_flag) report_mismatch("is_null", is_null, want.null_flag);
        if (running_min !== want.rmin) report_mismatch("running_min", running_min, want.rmin);
        if (running_max !== want.rmax) report_mismatch("running_max", running_max, want.rmax);
      end
    end
  end

  task automatic test_passthrough();
    send_pixel(16'd0, 0);
    send_pixel(16'd1, 0);
    send_pixel(16'hffff, 0);
    send_pixel(16'h5555, 0);
    send_pixel(16'haaaa, 0);
    drain();
  endtask

  task automatic test_directed();
    write_reg(REG_ENABLE, 32'd1);
    // unity defaults: y = count-1, negative values clamp to min_pix
    send_pixel(16'd0, 0);
    send_pixel(16'd1, 0);
    send_pixel(16'hffff, 0);
    send_pixel(16'd2, 0);
    drain();
    // zero divisor: xc = -1, y = 1.0
    write_reg(REG_GAIN, 32'd0);
    write_reg(REG_BIAS, 32'd0);
    write_reg(REG_COEF_XB, 32'hffff0000);
    write_reg(REG_COEF_XC, 32'hffff0000);
    send_pixel(16'd7, 0);
    drain();
    // extremes of every coefficient, saturation paths
    write_reg(REG_GAIN, 32'h7fffffff);
    write_reg(REG_BIAS, 32'h7fffffff);
    write_reg(REG_COEF_XA, 32'h80000000);
    write_reg(REG_COEF_XB, 32'h7fffffff);
    write_reg(REG_COEF_XC, 32'h80000000);
    write_reg(REG_MIN_PIX, 32'd65536);
    send_pixel(16'hffff, 0);
    send_pixel(16'd1, 0);
    drain();
    write_reg(REG_GAIN, 32'h80000000);
    write_reg(REG_BIAS, 32'h80000000);
    write_reg(REG_COEF_XA, 32'h7fffffff);
    write_reg(REG_COEF_XB, 32'h80000000);
    write_reg(REG_COEF_XC, 32'h00000000);
    write_reg(REG_MIN_PIX, 32'h1ffff);
    send_pixel(16'hffff, 0);
    send_pixel(16'h8000, 0);
    drain();
    // small reflectances for the running minimum
    write_reg(REG_GAIN, 32'd64);
    write_reg(REG_BIAS, 32'd0);
    write_reg(REG_COEF_XA, 32'd65536);
    write_reg(REG_COEF_XB, 32'd0);
    write_reg(REG_COEF_XC, 32'd0);
    write_reg(REG_MIN_PIX, 32'd0);
    send_pixel(16'd1, 0);
    send_pixel(16'd1000, 0);
    send_pixel(16'd10, 0);
    send_pixel(16'd0, 0);
    drain();
  endtask

  // One random configuration followed by a batch of random pixels
  task automatic test_random_phase(input int n_items);
    logic [31:0] v;
    write_reg(REG_ENABLE, {31'd0, ($urandom_range(0, 7) != 0)});
    write_reg(REG_GAIN, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 18));
    v = $urandom;
    write_reg(REG_BIAS, $urandom_range(0, 1) ? v : {{14{v[31]}}, v[17:0]});
    v = $urandom;
    write_reg(REG_COEF_XA, $urandom_range(0, 1) ? v : {{14{v[31]}}, v[17:0]});
    v = $urandom;
    write_reg(REG_COEF_XB, $urandom_range(0, 1) ? v : {{14{v[31]}}, v[17:0]});
    v = $urandom;
    write_reg(REG_COEF_XC, $urandom_range(0, 1) ? v : {{16{v[31]}}, v[15:0]});
    write_reg(REG_MIN_PIX, {15'd0, 17'($urandom_range(0, 65536))});
    if ($urandom_range(0, 3) == 0) write_reg(RegUnknown, $urandom);
    for (int i = 0; i < n_items; i++) begin
      case ($urandom_range(0, 9))
        0: send_pixel(16'd0, 1);
        1: send_pixel(16'hffff, 1);
        2: send_pixel(16'($urandom_range(1, 255)), 1);
        default: send_pixel(16'($urandom), 1);
      endcase
    end
    drain();
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_pixel(16'($urandom), 0);
    join
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    pixel_count = '0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    hold_off = 1'b0;
    rx_noise = 1'b0;
    error_count = 0;
    cycle_count = 0;
    p_enable = 1'b0;
    p_gain = 65536;
    p_bias = 0;
    p_xa = 65536;
    p_xb = 65536;
    p_xc = 65536;
    p_min_pix = 17'd1;
    p_stat_min = 17'd65536;
    p_stat_max = 17'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_passthrough();
    test_directed();
    test_backpressure();
    rx_noise = 1'b1;
    for (int ph = 0; ph < 34; ph++) begin
      // every fifth phase runs with the receiver quiet
      rx_noise = (ph % 5 != 4);
      test_random_phase(50);
    end
    drain();
    if (error_count == 0) begin
      $display("dn_to_surface_reflectance verification clean");
    end else begin
      $display("dn_to_surface_reflectance verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
